[rtl/vpcf_pkg.sv]
`default_nettype none
package vpcf_pkg;

    localparam int NUM_DIGITS = 10;
    localparam int BIN_BITS   = 32;
    localparam logic [4:0] CELL_COUNT = 5'd21;
    localparam logic [7:0] KEEP_MASK  = 8'hC0;
    localparam logic [7:0] SEG_MASK   = 8'h3F;

    localparam logic [1:0] OP_BARE   = 2'd0;
    localparam logic [1:0] OP_CELL   = 2'd1;
    localparam logic [1:0] OP_NUMBER = 2'd2;

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_BARE = 13'b0000000000010,
        S_CRD  = 13'b0000000000100,
        S_CMOD = 13'b0000000001000,
        S_BCD  = 13'b0000000010000,
        S_SIZE = 13'b0000000100000,
        S_NSEL = 13'b0000001000000,
        S_HDR  = 13'b0000010000000,
        S_CDAT = 13'b0000100000000,
        S_NRD  = 13'b0001000000000,
        S_NDAT = 13'b0010000000000,
        S_CHK  = 13'b0100000000000,
        S_REJ  = 13'b1000000000000
    } t_state;

    typedef enum logic [3:0] {
        DC_NONE,
        DC_LOAD,
        DC_BCD,
        DC_SIZE,
        DC_READ,
        DC_CELL_MOD,
        DC_EMIT_BARE,
        DC_EMIT_HDR,
        DC_EMIT_CDAT,
        DC_NDATA,
        DC_EMIT_CHK,
        DC_EMIT_REJ
    } t_dp_cmd;

    typedef struct packed {
        logic       can_emit;
        logic       bcd_last;
        logic       cell_bad;
        logic       off_bad;
        logic       tot_zero;
        logic       num_zero;
        logic       loop_last;
        logic       ndat_stall;
        logic       op_cell;
        logic [1:0] k;
    } t_dp_sts;

    function automatic logic [7:0] cell_offset(input logic [4:0] id);
        logic [7:0] r;
        case (id)
            5'd7:    r = 8'h16;
            5'd8:    r = 8'h01;
            5'd9:    r = 8'h04;
            5'd10:   r = 8'h07;
            5'd11:   r = 8'h0A;
            5'd12:   r = 8'h10;
            5'd13:   r = 8'h13;
            5'd14:   r = 8'h16;
            5'd15:   r = 8'h1C;
            5'd16:   r = 8'h1F;
            5'd17:   r = 8'h1E;
            5'd18:   r = 8'h1E;
            5'd19:   r = 8'h0A;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] cell_mask(input logic [4:0] id);
        logic [7:0] r;
        case (id)
            5'd0:    r = 8'h01;
            5'd1:    r = 8'h02;
            5'd2:    r = 8'h04;
            5'd3:    r = 8'h08;
            5'd4:    r = 8'h20;
            5'd5:    r = 8'h40;
            5'd6:    r = 8'h80;
            5'd7:    r = 8'h40;
            5'd8:    r = 8'h01;
            5'd16:   r = 8'h01;
            5'd18:   r = 8'h08;
            5'd19:   r = 8'h40;
            5'd20:   r = 8'h10;
            5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd17: r = 8'h80;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] digit_seg(input logic [3:0] d);
        logic [15:0] r;
        case (d)
            4'd0:    r = 16'h3123;
            4'd1:    r = 16'h1020;
            4'd2:    r = 16'h30c3;
            4'd3:    r = 16'h30e1;
            4'd4:    r = 16'h11e0;
            4'd5:    r = 16'h21e1;
            4'd6:    r = 16'h21e3;
            4'd7:    r = 16'h3020;
            4'd8:    r = 16'h31e3;
            4'd9:    r = 16'h31e1;
            default: r = 16'h0000;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/vpcf_if.sv]
`default_nettype none
// Request channel.
interface vpcf_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [7:0]  command_code;
    logic [4:0]  cell_id;
    logic        cell_on;
    logic [31:0] number_value;
    logic [3:0]  first_digit_pos;
    logic [3:0]  last_digit_pos;
    modport source (output valid, opcode, command_code, cell_id, cell_on, number_value,
                    first_digit_pos, last_digit_pos, input ready);
    modport sink (input valid, opcode, command_code, cell_id, cell_on, number_value,
                  first_digit_pos, last_digit_pos, output ready);
endinterface

// Frame byte channel.
interface vpcf_frm_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;
    logic       rejected;
    modport source (output valid, frame_byte, last_byte, rejected, input ready);
    modport sink (input valid, frame_byte, last_byte, rejected, output ready);
endinterface

// Configuration write channel.
interface vpcf_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] write_command_code;
    modport source (output valid, write_command_code, input ready);
    modport sink (input valid, write_command_code, output ready);
endinterface
`default_nettype wire

[rtl/vfd_panel_command_framer_top.sv]
`default_nettype none
// Channel   Dir  Beat contents
// i_req     in   opcode, command_code, cell_id, cell_on, number_value, digit positions
// o_frm     out  frame_byte, last_byte, rejected (one beat per frame byte)
// i_cfg     in   write_command_code
//
// A number request first converts its value from binary to decimal, then handles every
// data byte, bytes cut at the panel end included, with a read through the registered
// memory port followed by a write step.
// Reset is synchronous and clears the shadow valid bits at once, so no clearing
// pass is needed. A stalled output holds its byte and the sequencer waits on it.
module vfd_panel_command_framer_top import vpcf_pkg::*; #(
    parameter int PANEL_BYTES = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    vpcf_req_if.sink   i_req,
    vpcf_frm_if.source o_frm,
    vpcf_cfg_if.sink   i_cfg
);
    t_dp_cmd cmd;
    t_dp_sts sts;

    // Configuration writes are always taken; the user must issue them only while idle, the block does not enforce it.
    assign i_cfg.ready = 1'b1;

    vpcf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_opcode   (i_req.opcode),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    vpcf_datapath #(
        .PANEL_BYTES (PANEL_BYTES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_command_code    (i_req.command_code),
        .i_opcode          (i_req.opcode),
        .i_cell_id         (i_req.cell_id),
        .i_cell_on         (i_req.cell_on),
        .i_number_value    (i_req.number_value),
        .i_first_digit_pos (i_req.first_digit_pos),
        .i_last_digit_pos  (i_req.last_digit_pos),
        .i_cfg_we          (i_cfg.valid),
        .i_cfg_data        (i_cfg.write_command_code),
        .i_out_ready       (o_frm.ready),
        .o_out_valid       (o_frm.valid),
        .o_frame_byte      (o_frm.frame_byte),
        .o_last_byte       (o_frm.last_byte),
        .o_rejected        (o_frm.rejected)
    );

endmodule
`default_nettype wire

[rtl/vpcf_datapath.sv]
`default_nettype none
module vpcf_datapath import vpcf_pkg::*; #(
    parameter int PANEL_BYTES = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_dp_cmd     i_cmd,
    output t_dp_sts          o_sts,
    input  wire logic [7:0]  i_command_code,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [4:0]  i_cell_id,
    input  wire logic        i_cell_on,
    input  wire logic [31:0] i_number_value,
    input  wire logic [3:0]  i_first_digit_pos,
    input  wire logic [3:0]  i_last_digit_pos,
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        i_out_ready,
    output logic             o_out_valid,
    output logic [7:0]       o_frame_byte,
    output logic             o_last_byte,
    output logic             o_rejected
);
    localparam int DEPTH = PANEL_BYTES + 1;
    localparam int AW = $clog2(DEPTH);
    localparam logic [7:0] PB8 = 8'(PANEL_BYTES);

    logic [7:0]  r_shadow [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [7:0]  r_rd_data;
    logic        r_rd_ok;

    logic [1:0]  r_op;
    logic [7:0]  r_cmd;
    logic [4:0]  r_cell_id;
    logic        r_cell_on;
    logic [3:0]  r_first;
    logic [3:0]  r_last;
    logic [BIN_BITS-1:0] r_bin;
    logic [NUM_DIGITS-1:0][3:0] r_bcd;
    logic [4:0]  r_bitcnt;
    logic [4:0]  r_cnt;
    logic [5:0]  r_tot;
    logic [7:0]  r_off;
    logic [7:0]  r_num;
    logic [5:0]  r_j;
    logic [1:0]  r_ph;
    logic [3:0]  r_d;
    logic [1:0]  r_k;
    logic [7:0]  r_chk;
    logic [7:0]  r_wcc;
    logic [7:0]  r_cell_v;
    logic        r_out_vld;
    logic [7:0]  r_out_byte;
    logic        r_out_last;
    logic        r_out_rej;

    logic [7:0]  idx;
    logic        in_rng;
    logic [AW-1:0] addr;
    logic        can_emit;
    logic        off_bad;
    logic        need_emit;
    logic [4:0]  dig_idx;
    logic [3:0]  dig;
    logic [15:0] seg;
    logic [7:0]  old;
    logic [7:0]  nbyte;
    logic [7:0]  cell_v;
    logic        e_vld;
    logic [7:0]  e_byte;
    logic        e_last;
    logic        e_rej;
    logic        we;
    logic [7:0]  wd;
    logic [NUM_DIGITS-1:0][3:0] bcd_adj;
    logic [NUM_DIGITS*4:0] bcd_shift;
    logic [3:0]  sig;
    logic [4:0]  span;
    logic [4:0]  n_cnt;
    logic [5:0]  n_tot;
    logic [7:0]  n_off;
    logic [7:0]  n_num;

    assign idx      = (r_op == OP_CELL) ? r_off : r_off + {2'b00, r_j};
    assign in_rng   = (idx <= PB8);
    assign addr     = idx[AW-1:0];
    assign can_emit = !r_out_vld || i_out_ready;
    assign off_bad  = (r_off > PB8);
    assign need_emit = !off_bad && ({2'b00, r_j} < r_num);
    assign dig_idx  = 5'(r_cnt - 5'd1 - {1'b0, r_d});
    // Padding digits above the converted ones are zeros.
    assign dig      = (dig_idx < 5'(NUM_DIGITS)) ? r_bcd[dig_idx[3:0]] : 4'd0;
    assign seg      = digit_seg(dig);
    assign old      = r_rd_ok ? r_rd_data : 8'h00;
    assign cell_v   = r_cell_on ? (old | cell_mask(r_cell_id)) : (old & ~cell_mask(r_cell_id));

    always_comb begin
        case (r_ph)
            2'd0:    nbyte = seg[7:0];
            2'd1:    nbyte = (seg[15:8] & SEG_MASK) | (old & KEEP_MASK);
            default: nbyte = 8'h00;
        endcase
    end

    // Digit count, frame offset and clipped data count for a number request.
    always_comb begin
        sig = 4'd0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (r_bcd[i] != 4'd0) sig = 4'(i + 1);
        end
        span  = (r_last > r_first) ? 5'(r_last - r_first) + 5'd1 : 5'd0;
        n_cnt = (span > {1'b0, sig}) ? span : {1'b0, sig};
        n_tot = {n_cnt, 1'b0} + {1'b0, n_cnt};
        n_off = {3'b000, r_first, 1'b0} + {4'b0000, r_first} + 8'd3;
        n_num = ((n_off + {2'b00, n_tot}) > PB8) ? PB8 - n_off : {2'b00, n_tot};
    end

    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            bcd_adj[i] = (r_bcd[i] >= 4'd5) ? r_bcd[i] + 4'd3 : r_bcd[i];
        end
    end

    assign bcd_shift = {bcd_adj, r_bin[BIN_BITS-1]};

    always_comb begin
        e_vld  = 1'b0;
        e_byte = 8'h00;
        e_last = 1'b0;
        e_rej  = 1'b0;
        case (i_cmd)
            DC_EMIT_BARE: begin
                e_vld  = 1'b1;
                e_last = (r_k == 2'd2);
                e_byte = (r_k == 2'd2) ? r_chk : (r_k == 2'd1) ? r_cmd : 8'd1;
            end
            DC_EMIT_HDR: begin
                e_vld = 1'b1;
                case (r_k)
                    2'd0:    e_byte = r_num + 8'd3;
                    2'd1:    e_byte = r_wcc;
                    2'd2:    e_byte = r_off;
                    default: e_byte = r_num;
                endcase
            end
            DC_EMIT_CDAT: begin
                e_vld  = 1'b1;
                e_byte = r_cell_v;
            end
            DC_NDATA: begin
                e_vld  = need_emit;
                e_byte = nbyte;
            end
            DC_EMIT_CHK: begin
                e_vld  = 1'b1;
                e_byte = r_chk;
                e_last = 1'b1;
            end
            DC_EMIT_REJ: begin
                e_vld = 1'b1;
                e_rej = 1'b1;
            end
            default: begin
                e_vld = 1'b0;
            end
        endcase
    end

    assign we = (i_cmd == DC_CELL_MOD) || ((i_cmd == DC_NDATA) && in_rng);
    assign wd = (i_cmd == DC_CELL_MOD) ? cell_v : nbyte;

    // Shadow store: entries read as zero until first written.
    always_ff @(posedge i_clk) begin
        if (we) r_shadow[addr] <= wd;
        if (i_cmd == DC_READ && in_rng) r_rd_data <= r_shadow[addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (we) r_vld[addr] <= 1'b1;
            if (i_cmd == DC_READ) r_rd_ok <= in_rng && r_vld[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_wcc     <= 8'h00;
        end else begin
            if (i_cfg_we) r_wcc <= i_cfg_data;
            if (e_vld) r_out_vld <= 1'b1;
            else if (i_out_ready) r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_vld) begin
            r_out_byte <= e_byte;
            r_out_last <= e_last;
            r_out_rej  <= e_rej;
        end
        if (i_cmd == DC_LOAD) r_chk <= 8'h00;
        else if (e_vld && !e_last && !e_rej) r_chk <= r_chk ^ e_byte;

        case (i_cmd)
            DC_LOAD: begin
                r_op      <= i_opcode;
                r_cmd     <= i_command_code;
                r_cell_id <= i_cell_id;
                r_cell_on <= i_cell_on;
                r_first   <= i_first_digit_pos;
                r_last    <= i_last_digit_pos;
                r_bin     <= i_number_value;
                r_bcd     <= '0;
                r_bitcnt  <= 5'd0;
                r_off     <= cell_offset(i_cell_id);
                r_j       <= 6'd0;
                r_ph      <= 2'd0;
                r_d       <= 4'd0;
                r_k       <= 2'd0;
            end
            DC_BCD: begin
                r_bcd    <= bcd_shift[NUM_DIGITS*4-1:0];
                r_bin    <= {r_bin[BIN_BITS-2:0], 1'b0};
                r_bitcnt <= r_bitcnt + 5'd1;
            end
            DC_SIZE: begin
                r_cnt <= n_cnt;
                r_tot <= n_tot;
                r_off <= n_off;
                r_num <= n_num;
            end
            DC_CELL_MOD: begin
                r_cell_v <= cell_v;
                r_num    <= (r_off == PB8) ? 8'd0 : 8'd1;
            end
            DC_EMIT_BARE, DC_EMIT_HDR: begin
                r_k <= r_k + 2'd1;
            end
            DC_NDATA: begin
                r_j  <= r_j + 6'd1;
                r_ph <= (r_ph == 2'd2) ? 2'd0 : r_ph + 2'd1;
                if (r_ph == 2'd2) r_d <= r_d + 4'd1;
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

    always_comb begin
        o_sts.can_emit   = can_emit;
        o_sts.bcd_last   = (r_bitcnt == 5'(BIN_BITS - 1));
        o_sts.cell_bad   = (r_cell_id >= CELL_COUNT) || off_bad;
        o_sts.off_bad    = off_bad;
        o_sts.tot_zero   = (r_tot == 6'd0);
        o_sts.num_zero   = (r_num == 8'd0);
        o_sts.loop_last  = (r_j == r_tot - 6'd1);
        o_sts.ndat_stall = need_emit && !can_emit;
        o_sts.op_cell    = (r_op == OP_CELL);
        o_sts.k          = r_k;
    end

    assign o_out_valid  = r_out_vld;
    assign o_frame_byte = r_out_byte;
    assign o_last_byte  = r_out_last;
    assign o_rejected   = r_out_rej;

endmodule
`default_nettype wire

[rtl/vpcf_ctrl.sv]
`default_nettype none
module vpcf_ctrl import vpcf_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [1:0] i_opcode,
    input  wire t_dp_sts    i_sts,
    output t_dp_cmd         o_cmd
);
    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = DC_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd = DC_LOAD;
                    case (i_opcode)
                        OP_BARE:   n_state = S_BARE;
                        OP_CELL:   n_state = S_CRD;
                        OP_NUMBER: n_state = S_BCD;
                        default:   n_state = S_REJ;
                    endcase
                end
            end
            S_BARE: begin
                if (i_sts.can_emit) begin
                    o_cmd = DC_EMIT_BARE;
                    if (i_sts.k == 2'd2) n_state = S_IDLE;
                end
            end
            S_CRD: begin
                if (i_sts.cell_bad) begin
                    n_state = S_REJ;
                end else begin
                    o_cmd   = DC_READ;
                    n_state = S_CMOD;
                end
            end
            S_CMOD: begin
                o_cmd   = DC_CELL_MOD;
                n_state = S_HDR;
            end
            S_BCD: begin
                o_cmd = DC_BCD;
                if (i_sts.bcd_last) n_state = S_SIZE;
            end
            S_SIZE: begin
                o_cmd   = DC_SIZE;
                n_state = S_NSEL;
            end
            S_NSEL: begin
                if (!i_sts.off_bad) n_state = S_HDR;
                else if (i_sts.tot_zero) n_state = S_REJ;
                else n_state = S_NRD;
            end
            S_HDR: begin
                if (i_sts.can_emit) begin
                    o_cmd = DC_EMIT_HDR;
                    if (i_sts.k == 2'd3) begin
                        if (i_sts.op_cell) n_state = S_CDAT;
                        else if (i_sts.tot_zero) n_state = S_CHK;
                        else n_state = S_NRD;
                    end
                end
            end
            S_CDAT: begin
                if (i_sts.num_zero) begin
                    n_state = S_CHK;
                end else if (i_sts.can_emit) begin
                    o_cmd   = DC_EMIT_CDAT;
                    n_state = S_CHK;
                end
            end
            S_NRD: begin
                o_cmd   = DC_READ;
                n_state = S_NDAT;
            end
            S_NDAT: begin
                if (!i_sts.ndat_stall) begin
                    o_cmd = DC_NDATA;
                    if (!i_sts.loop_last) n_state = S_NRD;
                    else if (i_sts.off_bad) n_state = S_REJ;
                    else n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (i_sts.can_emit) begin
                    o_cmd   = DC_EMIT_CHK;
                    n_state = S_IDLE;
                end
            end
            S_REJ: begin
                if (i_sts.can_emit) begin
                    o_cmd   = DC_EMIT_REJ;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

[verif/tb_if.sv]
`timescale 1ns / 1ps
// The block's channel interfaces are declared in rtl/vpcf_if.sv; this file
// only holds the frame record shared by the scoreboard and the receiver.
package tb_frame_pkg;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
        logic       rejected;
    } t_frame_beat;

endpackage

[verif/tb.sv]
`timescale 1ns / 1ps
module tb;
    import vpcf_pkg::*;
    import tb_frame_pkg::*;

    // Panel geometry of the instance under test.
    localparam int PANEL_BYTES  = 32;
    localparam int SHADOW_DEPTH = PANEL_BYTES + 1;
    localparam int CYCLE_LIMIT  = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    vpcf_req_if req_ch ();
    vpcf_frm_if frm_ch ();
    vpcf_cfg_if cfg_ch ();

    vfd_panel_command_framer_top #(.PANEL_BYTES(PANEL_BYTES)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_frm   (frm_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    always #10 i_clk = ~i_clk;

    // The scoreboard keeps its own copy of the panel shadow and of the write command
    // code, computes the frame beats for each accepted request and checks them in order.
    class frame_scoreboard;
        logic [7:0]  shadow[SHADOW_DEPTH];
        logic [7:0]  write_cmd;
        t_frame_beat pending[$];
        int          errors;

        function void clear();
            foreach (shadow[i]) shadow[i] = 8'h00;
            write_cmd = 8'h00;
            errors = 0;
        endfunction

        function void push(logic [7:0] b, logic lst, logic rej);
            t_frame_beat f;
            f.frame_byte = b;
            f.last_byte = lst;
            f.rejected = rej;
            pending.push_back(f);
        endfunction

        // One-byte or multi-byte display write at a byte offset, cut at the panel end.
        function void frame_write(int unsigned off, logic [7:0] data[$]);
            int unsigned num;
            logic [7:0] chk;
            if (off > PANEL_BYTES) begin
                push(8'h00, 1'b0, 1'b1);
                return;
            end
            num = data.size();
            if (off + num > PANEL_BYTES) num = PANEL_BYTES - off;
            chk = 8'(num + 3);
            push(chk, 1'b0, 1'b0);
            chk ^= write_cmd;
            push(write_cmd, 1'b0, 1'b0);
            chk ^= 8'(off);
            push(8'(off), 1'b0, 1'b0);
            chk ^= 8'(num);
            push(8'(num), 1'b0, 1'b0);
            for (int unsigned i = 0; i < num; i++) begin
                chk ^= data[i];
                push(data[i], 1'b0, 1'b0);
            end
            push(chk, 1'b1, 1'b0);
        endfunction

        function void note_request(logic [1:0] op, logic [7:0] cmd, logic [4:0] id,
                                   logic on, logic [31:0] value, logic [3:0] first,
                                   logic [3:0] lastp);
            logic [7:0]  v;
            logic [7:0]  data[$];
            logic [3:0]  digits[$];
            logic [15:0] seg;
            logic [7:0]  old;
            int unsigned off, span, idx;
            data = {};
            digits = {};
            case (op)
                OP_BARE: begin
                    push(8'h01, 1'b0, 1'b0);
                    push(cmd, 1'b0, 1'b0);
                    push(8'h01 ^ cmd, 1'b1, 1'b0);
                end
                OP_CELL: begin
                    if (id >= CELL_COUNT || cell_off(id) > PANEL_BYTES) begin
                        push(8'h00, 1'b0, 1'b1);
                    end else begin
                        off = cell_off(id);
                        v = shadow[off];
                        if (on) v = v | cell_bit(id);
                        else v = v & ~cell_bit(id);
                        shadow[off] = v;
                        data.push_back(v);
                        frame_write(off, data);
                    end
                end
                OP_NUMBER: begin
                    span = (lastp > first) ? lastp - first + 1 : 0;
                    while (value != 0 && digits.size() < 16) begin
                        digits.push_front(4'(value % 10));
                        value = value / 10;
                    end
                    while (digits.size() < span) digits.push_front(4'd0);
                    off = first * 3 + 3;
                    foreach (digits[j]) begin
                        seg = seg_code(digits[j]);
                        idx = off + 3 * j + 1;
                        old = (idx < SHADOW_DEPTH) ? shadow[idx] : 8'h00;
                        data.push_back(seg[7:0]);
                        data.push_back((seg[15:8] & 8'h3F) | (old & 8'hC0));
                        data.push_back(8'h00);
                    end
                    foreach (data[j]) begin
                        if (off + j < SHADOW_DEPTH) shadow[off + j] = data[j];
                    end
                    frame_write(off, data);
                end
                default: push(8'h00, 1'b0, 1'b1);
            endcase
        endfunction

        function void check_beat(t_frame_beat got);
            t_frame_beat want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected beat, actual %h/%b/%b", $realtime,
                         got.frame_byte, got.last_byte, got.rejected);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (want !== got) begin
                $display("%0t: beat mismatch, expected %h/%b/%b actual %h/%b/%b",
                         $realtime, want.frame_byte, want.last_byte, want.rejected,
                         got.frame_byte, got.last_byte, got.rejected);
                errors++;
            end
        endfunction

        // Own lookup tables for the indicator cells and the digit segments.
        function int unsigned cell_off(logic [4:0] id);
            byte unsigned t[21] = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                    8'h16, 8'h01, 8'h04, 8'h07, 8'h0A, 8'h10, 8'h13,
                                    8'h16, 8'h1C, 8'h1F, 8'h1E, 8'h1E, 8'h0A, 8'h00};
            return t[id];
        endfunction

        function logic [7:0] cell_bit(logic [4:0] id);
            byte unsigned t[21] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h20, 8'h40, 8'h80,
                                    8'h40, 8'h01, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
                                    8'h80, 8'h80, 8'h01, 8'h80, 8'h08, 8'h40, 8'h10};
            return t[id];
        endfunction

        function logic [15:0] seg_code(logic [3:0] d);
            shortint unsigned t[10] = '{16'h3123, 16'h1020, 16'h30c3, 16'h30e1,
                                        16'h11e0, 16'h21e1, 16'h21e3, 16'h3020,
                                        16'h31e3, 16'h31e1};
            return t[d];
        endfunction
    endclass

    frame_scoreboard sb;
    int  cycle_count = 0;
    bit  rx_stall_mode = 1'b0;

    // The run is bounded by a cycle counter.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("vfd_panel_command_framer_top regression: fail");
            $finish;
        end
    end

    // The receiver checks every accepted beat and stalls on its own pattern: long
    // streaks of readiness alternate with bursty random backpressure.
    always @(posedge i_clk) begin
        t_frame_beat got;
        if (!i_rst_n) begin
            frm_ch.ready <= 1'b0;
        end else begin
            if (frm_ch.valid && frm_ch.ready) begin
                got.frame_byte = frm_ch.frame_byte;
                got.last_byte = frm_ch.last_byte;
                got.rejected = frm_ch.rejected;
                sb.check_beat(got);
            end
            if ($urandom_range(0, 63) == 0) rx_stall_mode <= ~rx_stall_mode;
            frm_ch.ready <= rx_stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
        end
    end

    // Burst state of the sender: requests go back to back within a burst.
    int burst_left = 0;

    // Sends one request, opening a random gap first when the current burst is used up.
    task automatic send_request(logic [1:0] op, logic [7:0] cmd, logic [4:0] id,
                                logic on, logic [31:0] value, logic [3:0] first,
                                logic [3:0] lastp);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        req_ch.valid <= 1'b1;
        req_ch.opcode <= op;
        req_ch.command_code <= cmd;
        req_ch.cell_id <= id;
        req_ch.cell_on <= on;
        req_ch.number_value <= value;
        req_ch.first_digit_pos <= first;
        req_ch.last_digit_pos <= lastp;
        do @(posedge i_clk); while (!(req_ch.valid && req_ch.ready));
        sb.note_request(op, cmd, id, on, value, first, lastp);
    endtask

    // Waits until every expected beat has come, then lets the block settle.
    task automatic drain();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // Writes the display write command register while the block is idle.
    task automatic write_config(logic [7:0] code);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.write_command_code <= code;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.write_cmd = code;
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_random();
        int          pick;
        logic [31:0] value;
        logic [3:0]  first;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0: value = $urandom();
            1: value = $urandom_range(0, 999);
            2: value = 32'd0;
            default: value = $urandom() >> $urandom_range(0, 31);
        endcase
        first = 4'($urandom_range(0, 15));
        if (pick < 20)
            send_request(OP_BARE, 8'($urandom()), 5'($urandom()), 1'($urandom()),
                         $urandom(), 4'($urandom()), 4'($urandom()));
        else if (pick < 55)
            send_request(OP_CELL, 8'($urandom()), (pick < 50) ? 5'($urandom_range(0, 20))
                         : 5'($urandom_range(21, 31)), 1'($urandom()), $urandom(),
                         4'($urandom()), 4'($urandom()));
        else if (pick < 97)
            send_request(OP_NUMBER, 8'($urandom()), 5'($urandom()), 1'($urandom()),
                         value, first, 4'($urandom_range(0, 15)));
        else
            send_request(2'd3, 8'($urandom()), 5'($urandom()), 1'($urandom()),
                         $urandom(), 4'($urandom()), 4'($urandom()));
    endtask

    initial begin
        sb = new();
        sb.clear();
        req_ch.valid = 1'b0;
        req_ch.opcode = OP_BARE;
        req_ch.command_code = 8'h00;
        req_ch.cell_id = 5'd0;
        req_ch.cell_on = 1'b0;
        req_ch.number_value = 32'd0;
        req_ch.first_digit_pos = 4'd0;
        req_ch.last_digit_pos = 4'd0;
        cfg_ch.valid = 1'b0;
        cfg_ch.write_command_code = 8'h00;
        frm_ch.ready = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with the reset value of the write command code.
        send_request(OP_BARE, 8'h00, 5'd0, 1'b0, 32'd0, 4'd0, 4'd0);
        send_request(OP_BARE, 8'hFF, 5'd31, 1'b1, 32'hFFFF_FFFF, 4'd15, 4'd15);
        send_request(OP_CELL, 8'h00, 5'd0, 1'b1, 32'd0, 4'd0, 4'd0);
        send_request(OP_CELL, 8'h00, 5'd20, 1'b1, 32'd0, 4'd0, 4'd0);
        send_request(OP_CELL, 8'h00, 5'd0, 1'b0, 32'd0, 4'd0, 4'd0);
        send_request(OP_CELL, 8'h00, 5'd16, 1'b1, 32'd0, 4'd0, 4'd0);
        send_request(OP_CELL, 8'h00, 5'd21, 1'b1, 32'd0, 4'd0, 4'd0);
        send_request(OP_CELL, 8'h00, 5'd31, 1'b0, 32'd0, 4'd0, 4'd0);
        send_request(2'd3, 8'h00, 5'd0, 1'b0, 32'd0, 4'd0, 4'd0);
        // Number with no digits, then the widest value and the widest padding.
        send_request(OP_NUMBER, 8'h00, 5'd0, 1'b0, 32'd0, 4'd0, 4'd0);
        send_request(OP_NUMBER, 8'h00, 5'd0, 1'b0, 32'hFFFF_FFFF, 4'd0, 4'd9);
        send_request(OP_NUMBER, 8'h00, 5'd0, 1'b0, 32'd7, 4'd0, 4'd15);
        // Cell bits that share the digit bytes must survive a digit write.
        send_request(OP_CELL, 8'h00, 5'd9, 1'b1, 32'd0, 4'd0, 4'd0);
        send_request(OP_NUMBER, 8'h00, 5'd0, 1'b0, 32'd1234567890, 4'd0, 4'd0);
        // Offsets near and past the panel end.
        send_request(OP_NUMBER, 8'h00, 5'd0, 1'b0, 32'd5, 4'd9, 4'd9);
        send_request(OP_NUMBER, 8'h00, 5'd0, 1'b0, 32'd42, 4'd8, 4'd9);
        send_request(OP_NUMBER, 8'h00, 5'd0, 1'b0, 32'd3, 4'd15, 4'd0);
        send_request(OP_NUMBER, 8'h00, 5'd0, 1'b0, 32'd0, 4'd10, 4'd12);

        // A bare command equal to the write code still has no payload.
        write_config(8'hFF);
        send_request(OP_BARE, 8'hFF, 5'd0, 1'b0, 32'd0, 4'd0, 4'd0);
        send_request(OP_CELL, 8'h00, 5'd17, 1'b1, 32'd0, 4'd0, 4'd0);
        send_request(OP_NUMBER, 8'h00, 5'd0, 1'b0, 32'h8000_0000, 4'd1, 4'd3);

        // Random part, with the write code changed between phases.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: write_config(8'h00);
                1: write_config(8'hA5);
                2: write_config(8'h5A);
                default: write_config(8'($urandom()));
            endcase
            for (int n = 0; n < 50; n++) begin
                send_random();
                // The sender holds off now and then until the block has gone quiet.
                if (n == 25) drain();
            end
        end

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("vfd_panel_command_framer_top regression: pass");
        end else begin
            $display("vfd_panel_command_framer_top regression: fail");
        end
        $finish;
    end

endmodule
